// ===== rtl/dial_button_dimmer_controller_top_assert.svh =====
// Assertion macros for the dial and button dimmer controller.
// Used by dial_button_dimmer_controller_top; no other dependencies.
`ifndef DIAL_BUTTON_DIMMER_CONTROLLER_TOP_ASSERT_SVH
`define DIAL_BUTTON_DIMMER_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define DBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dimmer controller check failed");

// Next-cycle implication under reset.
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dimmer controller check failed");

`endif

// ===== rtl/dbd_pkg.sv =====
// Package for the dial and button dimmer controller: payload types,
// register codes, reset values and the preset level and ramp rate tables.
`default_nettype none

package dbd_pkg;

    localparam int DIAL_W   = 10;
    localparam int LEVEL_W  = 16;
    localparam int SHIFT_W  = 4;
    localparam int PRESET_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIAL_HYSTERESIS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_SHIFT   = 2'd2;

    localparam logic [LEVEL_W-1:0] HYST_RESET    = 16'd2560;
    localparam logic [SHIFT_W-1:0] GAIN_RESET    = 4'd2;
    localparam logic [SHIFT_W-1:0] DAMPING_RESET = 4'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] PWM_FULL  = 16'(248 << 8);

    typedef struct packed {
        logic [DIAL_W-1:0] dial_sample;
        logic              button_level;
    } dbd_in_t;

    typedef struct packed {
        logic [7:0]          duty;
        logic                pwm_enable;
        logic                deep_sleep;
        logic                mode;
        logic [PRESET_W-1:0] preset_index;
    } dbd_out_t;

    function automatic logic [LEVEL_W-1:0] preset_level(input logic [PRESET_W-1:0] idx);
        logic [LEVEL_W-1:0] lvl;
        case (idx)
            3'd0:    lvl = 16'd0;
            3'd1:    lvl = 16'h0100;
            3'd2:    lvl = 16'd6349;
            3'd3:    lvl = 16'd15872;
            3'd4:    lvl = 16'd31744;
            default: lvl = PWM_FULL;
        endcase
        return lvl;
    endfunction

    function automatic logic [LEVEL_W-1:0] preset_rate(input logic [PRESET_W-1:0] idx);
        logic [LEVEL_W-1:0] rate;
        case (idx)
            3'd0:    rate = 16'(12 << 8);
            3'd1:    rate = 16'(1 << 8);
            3'd2:    rate = 16'(1 << 8);
            3'd3:    rate = 16'(2 << 8);
            3'd4:    rate = 16'(3 << 8);
            default: rate = 16'(5 << 8);
        endcase
        return rate;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dial_button_dimmer_controller_top.sv =====
// Dial and button dimmer controller: a tick passes from input transfer through
// the input register, then the result register, to result transfer.
// Throughput: one tick per cycle while out_stall is low; the step logic is
// a single pass between the input and result registers, state updated in place.
// Reset (rst_n, async): dial mode, brightness and filter state zero, preset 0,
// registers at their reset values. Mode-change ticks give no result.
`default_nettype none

`include "dial_button_dimmer_controller_top_assert.svh"

module dial_button_dimmer_controller_top #(
    parameter int NUM_PRESETS = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire dbd_pkg::dbd_in_t                 in_data,
    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      dbd_pkg::dbd_out_t                out_data,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [dbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dbd_pkg::LEVEL_W-1:0]      cfg_data
);
    import dbd_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0]  hyst_reg;
    logic [SHIFT_W-1:0]  gain_shift_reg;
    logic [SHIFT_W-1:0]  damping_shift_reg;

    // tick state
    logic                mode_reg, mode_next;
    logic [LEVEL_W-1:0]  bright_reg, bright_next;
    logic [LEVEL_W-1:0]  damp_reg, damp_next;
    logic                held_reg;
    logic                pending_reg, pending_next;
    logic [LEVEL_W-1:0]  trig_lo_reg, trig_lo_next;
    logic [LEVEL_W-1:0]  trig_hi_reg, trig_hi_next;
    logic [PRESET_W-1:0] preset_reg, preset_next;

    // pipeline registers
    logic                in_vld_reg;
    dbd_in_t             in_reg;
    logic                out_vld_reg;
    dbd_out_t            out_reg;

    logic                advance;
    logic                has_result;

    logic [LEVEL_W-1:0]  dial;
    logic                press_now;
    logic [LEVEL_W-1:0]  err;
    logic [LEVEL_W-1:0]  prop;
    logic [PRESET_W:0]   preset_inc;
    logic [PRESET_W-1:0] ramp_idx;
    logic [LEVEL_W-1:0]  target;
    logic [LEVEL_W-1:0]  step;
    logic signed [LEVEL_W:0] ramp_err;
    logic signed [LEVEL_W:0] step_s;

    assign cfg_ready = 1'b1;

    // Advance the held tick when the result register is free or draining.
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign dial      = {~in_reg.dial_sample, 6'b0};
    assign press_now = pending_reg || (!held_reg && in_reg.button_level);

    assign err  = dial - bright_reg;
    assign prop = LEVEL_W'($signed(err) >>> gain_shift_reg);

    assign preset_inc = {1'b0, preset_reg} + 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        bright_next  = bright_reg;
        damp_next    = damp_reg;
        pending_next = press_now;
        trig_lo_next = trig_lo_reg;
        trig_hi_next = trig_hi_reg;
        preset_next  = preset_reg;
        has_result   = 1'b1;
        ramp_idx     = preset_reg;

        if (!mode_reg) begin
            if (press_now) begin
                // enter button mode; latch the escape window, keep the press
                mode_next    = 1'b1;
                has_result   = 1'b0;
                trig_lo_next = (dial >= hyst_reg) ? dial - hyst_reg : '0;
                trig_hi_next = (dial < (LEVEL_MAX ^ hyst_reg)) ? dial + hyst_reg
                                                                : LEVEL_MAX;
            end else begin
                bright_next = bright_reg + prop + damp_reg;
                damp_next   = LEVEL_W'($signed(prop) >>> damping_shift_reg);
            end
        end else if (dial < trig_lo_reg || dial > trig_hi_reg) begin
            mode_next  = 1'b0;
            has_result = 1'b0;
        end else begin
            if (press_now) begin
                pending_next = 1'b0;
                preset_next  = (preset_inc >= (PRESET_W+1)'(NUM_PRESETS))
                               ? '0 : preset_inc[PRESET_W-1:0];
                ramp_idx     = preset_next;
            end
            if (ramp_err > step_s)
                bright_next = bright_reg + step;
            else if (ramp_err < -step_s)
                bright_next = bright_reg - step;
            else
                bright_next = target;
        end
    end

    assign target   = preset_level(ramp_idx);
    assign step     = preset_rate(ramp_idx);
    assign step_s   = $signed({1'b0, step});
    assign ramp_err = $signed({2'b0, target[LEVEL_W-1:1]})
                    - $signed({2'b0, bright_reg[LEVEL_W-1:1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hyst_reg          <= HYST_RESET;
            gain_shift_reg    <= GAIN_RESET;
            damping_shift_reg <= DAMPING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DIAL_HYSTERESIS: hyst_reg          <= cfg_data;
                CFG_GAIN_SHIFT:      gain_shift_reg    <= cfg_data[SHIFT_W-1:0];
                CFG_DAMPING_SHIFT:   damping_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= 1'b0;
            bright_reg  <= '0;
            damp_reg    <= '0;
            held_reg    <= 1'b0;
            pending_reg <= 1'b0;
            trig_lo_reg <= '0;
            trig_hi_reg <= '0;
            preset_reg  <= '0;
        end else if (advance) begin
            mode_reg    <= mode_next;
            bright_reg  <= bright_next;
            damp_reg    <= damp_next;
            held_reg    <= in_reg.button_level;
            pending_reg <= pending_next;
            trig_lo_reg <= trig_lo_next;
            trig_hi_reg <= trig_hi_next;
            preset_reg  <= preset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance && has_result)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_reg <= in_data;
        if (advance && has_result) begin
            out_reg.duty         <= bright_next[LEVEL_W-1:8];
            out_reg.pwm_enable   <= |bright_next[LEVEL_W-1:8];
            out_reg.deep_sleep   <= ~|bright_next[LEVEL_W-1:8];
            out_reg.mode         <= mode_next;
            out_reg.preset_index <= preset_next;
        end
    end

    `DBD_ASSERT_NOW(a_stall_only_when_held, clk, rst_n, !in_vld_reg, !in_stall)
    `DBD_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && has_result, out_valid)
    `DBD_ASSERT_NEXT(a_no_result_on_mode_change, clk, rst_n,
                     advance && (mode_next != mode_reg) && !out_stall, !out_valid)
    `DBD_ASSERT_NOW(a_preset_in_range, clk, rst_n, 1'b1,
                    {1'b0, preset_reg} < (PRESET_W+1)'(NUM_PRESETS))

endmodule

`default_nettype wire
